@@ rtl/core/fecrl_pkg.sv @@
// Package for the flow event age curve rate limiter: sizes, codes and the flow table entry type.
`default_nettype none
package fecrl_pkg;

    // FLOW_ENTRIES must be a power of two.
    localparam int FLOW_ENTRIES = 65536;
    localparam int FLOW_IDX_W   = $clog2(FLOW_ENTRIES);
    localparam logic [15:0] FLOW_MASK = 16'(FLOW_ENTRIES - 1);

    localparam int TIME_W = 64;
    localparam int CFG_W  = 63;

    typedef enum logic [2:0] {
        REG_CAPTURE_ALL     = 3'd0,
        REG_COOLDOWN_ENABLE = 3'd1,
        REG_BAND0_AGE_LIMIT = 3'd2,
        REG_BAND1_AGE_LIMIT = 3'd3,
        REG_BAND2_AGE_LIMIT = 3'd4,
        REG_BAND0_INTERVAL  = 3'd5,
        REG_BAND1_INTERVAL  = 3'd6,
        REG_BAND2_INTERVAL  = 3'd7
    } cfg_reg_t;

    typedef enum logic [1:0] {
        FUNC_ADD    = 2'd0,
        FUNC_UPDATE = 2'd1,
        FUNC_DELETE = 2'd2
    } func_t;

    typedef enum logic [2:0] {
        DROP_NONE         = 3'd0,
        DROP_STATUS       = 3'd1,
        DROP_NOT_SELECTED = 3'd2,
        DROP_NO_COUNTERS  = 3'd3,
        DROP_COOLING      = 3'd4,
        DROP_TOO_YOUNG    = 3'd5
    } drop_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_BAND,
        ST_WRITE
    } state_t;

    typedef struct packed {
        logic              cd_valid;
        logic [TIME_W-1:0] cd_expiry;
        logic              or_valid;
        logic [TIME_W-1:0] or_time;
    } tbl_entry_t;

endpackage
`default_nettype wire

@@ rtl/core/flow_event_age_curve_rate_limiter.sv @@
// Flow event age curve rate limiter: per-flow cooldown and origin tables in one synchronous RAM.
// An accepted request passes the read, age, band and write-back steps before its result is
// loaded into the output register. No new request is taken until the last one finishes its write-back
// on the single flow table RAM port; write-back waits while the output register is held.
// Reset: config registers clear; a clearing pass then zeroes all FLOW_ENTRIES (65536) entries of
// the flow table, during which no input request is taken; config writes are taken as ever.
`default_nettype none
module flow_event_age_curve_rate_limiter
    import fecrl_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,

    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [2:0]        cfg_index,
    input  wire logic [63:0]       cfg_data,

    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [1:0]        func,
    input  wire logic [15:0]       flow_index,
    input  wire logic [TIME_W-1:0] timestamp,
    input  wire logic              status_active,
    input  wire logic              flowlog_marked,
    input  wire logic              counters_present,
    input  wire logic [63:0]       packets_fwd,
    input  wire logic [63:0]       packets_reply,

    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic                   emit,
    output logic [1:0]             event_kind,
    output logic [2:0]             drop_reason,
    output logic [CFG_W-1:0]       interval_set
);

    tbl_entry_t tbl_mem [FLOW_ENTRIES];
    tbl_entry_t rd_data_reg;

    state_t state_reg, state_next;
    logic [FLOW_IDX_W-1:0] clr_cnt_reg;

    logic             capture_all_reg;
    logic             cooldown_enable_reg;
    logic [CFG_W-1:0] band0_age_limit_reg;
    logic [CFG_W-1:0] band1_age_limit_reg;
    logic [CFG_W-1:0] band2_age_limit_reg;
    logic [CFG_W-1:0] band0_interval_reg;
    logic [CFG_W-1:0] band1_interval_reg;
    logic [CFG_W-1:0] band2_interval_reg;

    logic [1:0]            kind_reg;
    logic [FLOW_IDX_W-1:0] slot_reg;
    logic [TIME_W-1:0]     ts_reg;
    logic                  status_reg;
    logic                  selected_reg;
    logic                  counters_reg;
    logic                  pkts2_reg;
    logic [TIME_W-1:0]     backdate_reg;

    logic                  cool_hit_reg;
    logic [TIME_W-1:0]     origin_reg;
    logic [TIME_W-1:0]     age_reg;
    logic                  young_reg;
    logic [CFG_W-1:0]      interval_reg;

    logic                  out_valid_reg;
    logic                  emit_reg;
    logic [1:0]            event_kind_reg;
    logic [2:0]            drop_reason_reg;
    logic [CFG_W-1:0]      interval_set_reg;

    logic                  in_req;
    logic [FLOW_IDX_W-1:0] in_slot;
    logic [64:0]           pkt_sum;
    logic                  in_pkts2;
    logic [TIME_W-1:0]     band1_ext;
    logic [TIME_W-1:0]     in_backdate;

    logic [TIME_W-1:0]     origin_sel;
    logic [TIME_W:0]       next_sum;
    logic [TIME_W-1:0]     next_expiry;
    logic                  is_delete;
    logic                  pass_checks;
    logic                  done;

    logic                  mem_we;
    logic [FLOW_IDX_W-1:0] mem_waddr;
    tbl_entry_t            mem_wdata;
    logic                  res_emit;
    drop_t                 res_reason;
    logic [CFG_W-1:0]      res_interval;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE);
    assign in_req    = in_valid && in_ready;
    assign in_slot   = FLOW_IDX_W'(flow_index & FLOW_MASK);

    assign pkt_sum     = {1'b0, packets_fwd} + {1'b0, packets_reply};
    assign in_pkts2    = pkt_sum[64] || (pkt_sum[63:1] != 63'd0);
    assign band1_ext   = {1'b0, band1_age_limit_reg};
    assign in_backdate = (timestamp > band1_ext) ? timestamp - band1_ext : '0;

    assign origin_sel = rd_data_reg.or_valid ? rd_data_reg.or_time
                      : (pkts2_reg ? backdate_reg : ts_reg);

    assign next_sum    = {1'b0, ts_reg} + {2'b00, interval_reg};
    assign next_expiry = next_sum[TIME_W] ? '1 : next_sum[TIME_W-1:0];

    assign is_delete   = (kind_reg == FUNC_DELETE);
    assign pass_checks = status_reg && selected_reg && counters_reg;
    assign done        = (state_reg == ST_WRITE) && !(out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capture_all_reg     <= 1'b0;
            cooldown_enable_reg <= 1'b0;
            band0_age_limit_reg <= '0;
            band1_age_limit_reg <= '0;
            band2_age_limit_reg <= '0;
            band0_interval_reg  <= '0;
            band1_interval_reg  <= '0;
            band2_interval_reg  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_CAPTURE_ALL:     capture_all_reg     <= cfg_data[0];
                REG_COOLDOWN_ENABLE: cooldown_enable_reg <= cfg_data[0];
                REG_BAND0_AGE_LIMIT: band0_age_limit_reg <= cfg_data[CFG_W-1:0];
                REG_BAND1_AGE_LIMIT: band1_age_limit_reg <= cfg_data[CFG_W-1:0];
                REG_BAND2_AGE_LIMIT: band2_age_limit_reg <= cfg_data[CFG_W-1:0];
                REG_BAND0_INTERVAL:  band0_interval_reg  <= cfg_data[CFG_W-1:0];
                REG_BAND1_INTERVAL:  band1_interval_reg  <= cfg_data[CFG_W-1:0];
                REG_BAND2_INTERVAL:  band2_interval_reg  <= cfg_data[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        mem_we       = 1'b0;
        mem_waddr    = slot_reg;
        mem_wdata    = rd_data_reg;
        res_emit     = 1'b0;
        res_reason   = DROP_NONE;
        res_interval = '0;

        if (!pass_checks)
        begin
            res_reason = !status_reg   ? DROP_STATUS
                       : !selected_reg ? DROP_NOT_SELECTED
                       :                 DROP_NO_COUNTERS;
        end
        else if (is_delete)
        begin
            res_emit = 1'b1;
        end
        else if (cool_hit_reg)
        begin
            res_reason = DROP_COOLING;
        end
        else if (!cooldown_enable_reg)
        begin
            res_emit = 1'b1;
        end
        else if (young_reg)
        begin
            res_reason = DROP_TOO_YOUNG;
        end
        else
        begin
            res_emit     = 1'b1;
            res_interval = interval_reg;
        end

        if (is_delete)
        begin
            mem_wdata.cd_valid = 1'b0;
            mem_wdata.or_valid = 1'b0;
        end
        else
        begin
            mem_wdata.or_valid = 1'b1;
            mem_wdata.or_time  = origin_reg;
            if (cooldown_enable_reg && !young_reg)
            begin
                mem_wdata.cd_valid  = 1'b1;
                mem_wdata.cd_expiry = next_expiry;
            end
        end

        case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_cnt_reg;
                mem_wdata = '0;
                if (clr_cnt_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_req)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:  state_next = ST_BAND;
            ST_BAND:  state_next = ST_WRITE;
            ST_WRITE:
            begin
                if (done)
                begin
                    mem_we     = is_delete || (pass_checks && !cool_hit_reg);
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            tbl_mem[mem_waddr] <= mem_wdata;
        end
        if (in_req)
        begin
            rd_data_reg <= tbl_mem[in_slot];
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_req)
        begin
            kind_reg     <= func[1] ? FUNC_DELETE : func;
            slot_reg     <= in_slot;
            ts_reg       <= timestamp;
            status_reg   <= status_active;
            selected_reg <= capture_all_reg || flowlog_marked;
            counters_reg <= counters_present;
            pkts2_reg    <= in_pkts2;
            backdate_reg <= in_backdate;
        end
        if (state_reg == ST_READ)
        begin
            cool_hit_reg <= cooldown_enable_reg && pkts2_reg && rd_data_reg.cd_valid
                            && (ts_reg < rd_data_reg.cd_expiry);
            origin_reg   <= origin_sel;
            age_reg      <= (ts_reg >= origin_sel) ? ts_reg - origin_sel : '0;
        end
        if (state_reg == ST_BAND)
        begin
            young_reg <= age_reg < {1'b0, band0_age_limit_reg};
            if (age_reg < {1'b0, band1_age_limit_reg})
            begin
                interval_reg <= band0_interval_reg;
            end
            else if (age_reg < {1'b0, band2_age_limit_reg})
            begin
                interval_reg <= band1_interval_reg;
            end
            else
            begin
                interval_reg <= band2_interval_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (done)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done)
        begin
            emit_reg         <= res_emit;
            event_kind_reg   <= kind_reg;
            drop_reason_reg  <= res_reason;
            interval_set_reg <= res_interval;
        end
    end

    assign out_valid    = out_valid_reg;
    assign emit         = emit_reg;
    assign event_kind   = event_kind_reg;
    assign drop_reason  = drop_reason_reg;
    assign interval_set = interval_set_reg;

endmodule
`default_nettype wire

@@ dv/fecrl_checker.sv @@
// Checker for the flow event rate limiter: predicts each request's verdict and compares results.
module fecrl_checker
    import fecrl_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic [2:0]        cfg_index,
    input  logic [63:0]       cfg_data,
    input  logic              in_valid,
    input  logic              in_ready,
    input  logic [1:0]        func,
    input  logic [15:0]       flow_index,
    input  logic [TIME_W-1:0] timestamp,
    input  logic              status_active,
    input  logic              flowlog_marked,
    input  logic              counters_present,
    input  logic [63:0]       packets_fwd,
    input  logic [63:0]       packets_reply,
    input  logic              out_valid,
    input  logic              out_ready,
    input  logic              emit,
    input  logic [1:0]        event_kind,
    input  logic [2:0]        drop_reason,
    input  logic [CFG_W-1:0]  interval_set,
    output int                fail_count,
    output int                pending_results,
    output int                request_count,
    output int                result_count,
    output int                emit_count,
    output int                cooling_count,
    output int                young_count
);

    typedef struct {
        logic             emit;
        func_t            kind;
        drop_t            reason;
        logic [CFG_W-1:0] interval;
    } verdict_t;

    // shadow of the configuration
    logic             cap_all;
    logic             cd_on;
    logic [CFG_W-1:0] age_limit [3];
    logic [CFG_W-1:0] band_gap [3];

    // shadow of the flow tables
    logic              cd_valid [FLOW_ENTRIES];
    logic [TIME_W-1:0] cd_expiry [FLOW_ENTRIES];
    logic              or_valid [FLOW_ENTRIES];
    logic [TIME_W-1:0] or_time [FLOW_ENTRIES];

    verdict_t pending_verdicts [$];

    function automatic verdict_t judge_event(
        input logic [1:0]        fn,
        input logic [15:0]       idx,
        input logic [TIME_W-1:0] ts,
        input logic              st,
        input logic              mk,
        input logic              ctr,
        input logic [63:0]       po,
        input logic [63:0]       pr
    );
        verdict_t              v;
        logic [FLOW_IDX_W-1:0] slot;
        logic                  del;
        logic [64:0]           wide_sum;
        logic [63:0]           pkts;
        logic [63:0]           origin;
        logic [63:0]           age;
        logic [CFG_W-1:0]      gap;
        slot = FLOW_IDX_W'(idx & FLOW_MASK);
        del = fn[1];
        v.emit = 1'b0;
        v.kind = del ? FUNC_DELETE : func_t'(fn);
        v.reason = DROP_NONE;
        v.interval = '0;
        if (del)
        begin
            cd_valid[slot] = 1'b0;
            or_valid[slot] = 1'b0;
        end
        if (!st)
            v.reason = DROP_STATUS;
        else if (!cap_all && !mk)
            v.reason = DROP_NOT_SELECTED;
        else if (!ctr)
            v.reason = DROP_NO_COUNTERS;
        else if (del)
            v.emit = 1'b1;
        else
        begin
            wide_sum = {1'b0, po} + {1'b0, pr};
            pkts = wide_sum[64] ? '1 : wide_sum[63:0];
            if (cd_on && pkts > 64'd1 && cd_valid[slot] && ts < cd_expiry[slot])
                v.reason = DROP_COOLING;
            else
            begin
                if (!or_valid[slot])
                begin
                    origin = ts;
                    if (pkts >= 64'd2)
                        origin = (ts > {1'b0, age_limit[1]}) ? ts - {1'b0, age_limit[1]} : '0;
                    or_time[slot] = origin;
                    or_valid[slot] = 1'b1;
                end
                if (!cd_on)
                    v.emit = 1'b1;
                else
                begin
                    age = (ts >= or_time[slot]) ? ts - or_time[slot] : '0;
                    if (age < {1'b0, age_limit[0]})
                        v.reason = DROP_TOO_YOUNG;
                    else
                    begin
                        if (age < {1'b0, age_limit[1]})
                            gap = band_gap[0];
                        else if (age < {1'b0, age_limit[2]})
                            gap = band_gap[1];
                        else
                            gap = band_gap[2];
                        wide_sum = {1'b0, ts} + {2'b0, gap};
                        cd_expiry[slot] = wide_sum[64] ? '1 : wide_sum[63:0];
                        cd_valid[slot] = 1'b1;
                        v.emit = 1'b1;
                        v.interval = gap;
                    end
                end
            end
        end
        return v;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        verdict_t v;
        if (!rst_n)
        begin
            cap_all = 1'b0;
            cd_on = 1'b0;
            age_limit = '{default: '0};
            band_gap = '{default: '0};
            foreach (cd_valid[i])
            begin
                cd_valid[i] = 1'b0;
                or_valid[i] = 1'b0;
            end
            pending_verdicts.delete();
            fail_count <= 0;
            pending_results <= 0;
            request_count <= 0;
            result_count <= 0;
            emit_count <= 0;
            cooling_count <= 0;
            young_count <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_CAPTURE_ALL:     cap_all = cfg_data[0];
                    REG_COOLDOWN_ENABLE: cd_on = cfg_data[0];
                    REG_BAND0_AGE_LIMIT: age_limit[0] = cfg_data[CFG_W-1:0];
                    REG_BAND1_AGE_LIMIT: age_limit[1] = cfg_data[CFG_W-1:0];
                    REG_BAND2_AGE_LIMIT: age_limit[2] = cfg_data[CFG_W-1:0];
                    REG_BAND0_INTERVAL:  band_gap[0] = cfg_data[CFG_W-1:0];
                    REG_BAND1_INTERVAL:  band_gap[1] = cfg_data[CFG_W-1:0];
                    REG_BAND2_INTERVAL:  band_gap[2] = cfg_data[CFG_W-1:0];
                    default: ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                result_count <= result_count + 1;
                if (pending_verdicts.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("[%0t] result with no request outstanding", $realtime);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    v = pending_verdicts.pop_front();
                    if (v.emit) emit_count <= emit_count + 1;
                    if (v.reason == DROP_COOLING) cooling_count <= cooling_count + 1;
                    if (v.reason == DROP_TOO_YOUNG) young_count <= young_count + 1;
                    if (emit !== v.emit || event_kind !== v.kind ||
                        drop_reason !== v.reason || interval_set !== v.interval)
                    begin
                        if (fail_count < 10)
                            $display("[%0t] mismatch: expected emit=%0b kind=%0d reason=%0d ",
                                     $realtime, v.emit, v.kind, v.reason,
                                     "interval=%0d, got emit=%0b kind=%0d reason=%0d ",
                                     v.interval, emit, event_kind, drop_reason,
                                     "interval=%0d", interval_set);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                request_count <= request_count + 1;
                pending_verdicts.push_back(judge_event(func, flow_index, timestamp,
                    status_active, flowlog_marked, counters_present, packets_fwd,
                    packets_reply));
            end
            pending_results <= pending_verdicts.size();
        end
    end

endmodule

@@ dv/tb_flow_event_age_curve_rate_limiter.sv @@
// Testbench top for the flow event rate limiter: clock, reset, request stimulus and verdict.
module tb_flow_event_age_curve_rate_limiter;
    import fecrl_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 1000000;
    localparam logic [1:0] FUNC_RESERVED = 2'd3;
    localparam logic [CFG_W-1:0] CFG_MAX = '1;

    typedef enum {CURVE_TYPICAL, CURVE_ZERO, CURVE_MAX, CURVE_RANDOM, CURVE_OFF} curve_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [2:0]        cfg_index = '0;
    logic [63:0]       cfg_data = '0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic [1:0]        func = '0;
    logic [15:0]       flow_index = '0;
    logic [TIME_W-1:0] timestamp = '0;
    logic              status_active = 1'b0;
    logic              flowlog_marked = 1'b0;
    logic              counters_present = 1'b0;
    logic [63:0]       packets_fwd = '0;
    logic [63:0]       packets_reply = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic              emit;
    logic [1:0]        event_kind;
    logic [2:0]        drop_reason;
    logic [CFG_W-1:0]  interval_set;

    int fail_count;
    int pending_results;
    int request_count;
    int result_count;
    int emit_count;
    int cooling_count;
    int young_count;

    int unsigned tx_idle_pct = 0;
    int unsigned rx_stall_pct = 0;
    logic        squeeze_req = 1'b0;
    int unsigned squeeze_left = 400;
    int unsigned cycle_count = 0;
    int unsigned ts_span = 400;
    logic [63:0] now_ns = 64'd100000;
    logic [15:0] flow_pool [16];

    flow_event_age_curve_rate_limiter dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready), .func(func), .flow_index(flow_index),
        .timestamp(timestamp), .status_active(status_active),
        .flowlog_marked(flowlog_marked), .counters_present(counters_present),
        .packets_fwd(packets_fwd), .packets_reply(packets_reply),
        .out_valid(out_valid), .out_ready(out_ready), .emit(emit),
        .event_kind(event_kind), .drop_reason(drop_reason), .interval_set(interval_set)
    );

    fecrl_checker event_check (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready), .func(func), .flow_index(flow_index),
        .timestamp(timestamp), .status_active(status_active),
        .flowlog_marked(flowlog_marked), .counters_present(counters_present),
        .packets_fwd(packets_fwd), .packets_reply(packets_reply),
        .out_valid(out_valid), .out_ready(out_ready), .emit(emit),
        .event_kind(event_kind), .drop_reason(drop_reason), .interval_set(interval_set),
        .fail_count(fail_count), .pending_results(pending_results),
        .request_count(request_count), .result_count(result_count),
        .emit_count(emit_count), .cooling_count(cooling_count), .young_count(young_count)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("** flow_event_age_curve_rate_limiter: FAILED **");
            $finish;
        end
    end

    // receiver: random stalls, plus one long hold-off to back the block up
    always @(posedge clk)
    begin
        if (squeeze_req && squeeze_left != 0)
        begin
            out_ready <= 1'b0;
            squeeze_left <= squeeze_left - 1;
        end
        else
            out_ready <= ($urandom_range(99) >= rx_stall_pct);
    end

    task automatic send_event(input logic [1:0] f, input logic [15:0] idx,
                              input logic [63:0] ts, input logic st, input logic mk,
                              input logic ctr, input logic [63:0] po, input logic [63:0] pr);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        func <= f;
        flow_index <= idx;
        timestamp <= ts;
        status_active <= st;
        flowlog_marked <= mk;
        counters_present <= ctr;
        packets_fwd <= po;
        packets_reply <= pr;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t r, input logic [63:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= r;
        cfg_data <= d;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    // stop offering, let every outstanding result drain, then allow the pipe to settle
    task automatic drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results != 0);
        repeat (8) @(posedge clk);
    endtask

    task automatic apply_setting(input logic cap, input logic cd,
                                 input logic [CFG_W-1:0] l0, input logic [CFG_W-1:0] l1,
                                 input logic [CFG_W-1:0] l2, input logic [CFG_W-1:0] g0,
                                 input logic [CFG_W-1:0] g1, input logic [CFG_W-1:0] g2);
        drain();
        write_reg(REG_CAPTURE_ALL, {63'({$urandom, $urandom}), cap});
        write_reg(REG_COOLDOWN_ENABLE, {63'({$urandom, $urandom}), cd});
        write_reg(REG_BAND0_AGE_LIMIT, {1'($urandom), l0});
        write_reg(REG_BAND1_AGE_LIMIT, {1'($urandom), l1});
        write_reg(REG_BAND2_AGE_LIMIT, {1'($urandom), l2});
        write_reg(REG_BAND0_INTERVAL, {1'($urandom), g0});
        write_reg(REG_BAND1_INTERVAL, {1'($urandom), g1});
        write_reg(REG_BAND2_INTERVAL, {1'($urandom), g2});
        cfg_valid <= 1'b0;
    endtask

    task automatic choose_setting(input curve_t c);
        logic [CFG_W-1:0] l0;
        logic [CFG_W-1:0] l1;
        logic [CFG_W-1:0] l2;
        if (now_ns[63])
            now_ns = {32'h0, $urandom};
        l0 = CFG_W'($urandom_range(2000));
        l1 = l0 + CFG_W'($urandom_range(5000));
        l2 = l1 + CFG_W'($urandom_range(20000));
        case (c)
            CURVE_TYPICAL:
            begin
                apply_setting(1'b1, 1'b1, 100, 1000, 10000, 50, 500, 5000);
                ts_span = 400;
            end
            CURVE_ZERO:
            begin
                apply_setting(1'b1, 1'b1, 0, 0, 0, 0, 0, 0);
                ts_span = 50;
            end
            CURVE_MAX:
            begin
                apply_setting(1'b1, 1'b1, CFG_MAX, CFG_MAX, CFG_MAX, CFG_MAX, CFG_MAX, CFG_MAX);
                now_ns = 64'hFFFF_FFFF_FFF0_0000;
                ts_span = 1000;
            end
            CURVE_RANDOM:
            begin
                apply_setting(1'($urandom), 1'b1, l0, l1, l2, CFG_W'($urandom_range(8000)),
                              CFG_W'($urandom_range(8000)), CFG_W'($urandom_range(8000)));
                ts_span = 3000;
            end
            default:
            begin
                apply_setting(1'($urandom), 1'b0, l0, l1, l2, CFG_W'($urandom_range(8000)),
                              CFG_W'($urandom_range(8000)), CFG_W'($urandom_range(8000)));
                ts_span = 100;
            end
        endcase
    endtask

    // coherent traffic on a small set of flows, with some stray slots and wild timestamps
    task automatic random_event();
        logic [1:0]  f;
        logic [15:0] idx;
        logic [63:0] ts;
        logic [63:0] po;
        logic [63:0] pr;
        int unsigned roll;
        roll = $urandom_range(99);
        f = (roll < 30) ? FUNC_ADD : (roll < 75) ? FUNC_UPDATE :
            (roll < 92) ? FUNC_DELETE : FUNC_RESERVED;
        idx = ($urandom_range(9) == 0) ? 16'($urandom) : flow_pool[4'($urandom_range(15))];
        now_ns = now_ns + 64'($urandom_range(ts_span));
        roll = $urandom_range(99);
        if (roll < 5)
            ts = now_ns - 64'($urandom_range(4 * ts_span));
        else if (roll < 8)
            ts = {$urandom, $urandom};
        else
            ts = now_ns;
        roll = $urandom_range(99);
        if (roll < 25)
        begin
            po = 64'($urandom_range(1));
            pr = 64'($urandom_range(1));
        end
        else if (roll < 92)
        begin
            po = 64'($urandom_range(1000));
            pr = 64'($urandom_range(1000));
        end
        else
        begin
            po = {$urandom, $urandom};
            pr = {$urandom, $urandom};
        end
        send_event(f, idx, ts, $urandom_range(99) < 95, $urandom_range(99) < 70,
                   $urandom_range(99) < 95, po, pr);
    endtask

    initial
    begin
        curve_t phase_curve [8];
        int unsigned tx_mode [4];
        int unsigned rx_mode [4];
        phase_curve = '{CURVE_TYPICAL, CURVE_TYPICAL, CURVE_ZERO, CURVE_MAX,
                        CURVE_RANDOM, CURVE_OFF, CURVE_RANDOM, CURVE_TYPICAL};
        tx_mode = '{0, 47, 0, 16};
        rx_mode = '{0, 0, 47, 16};
        flow_pool[0] = 16'h0000;
        flow_pool[1] = 16'hFFFF;
        for (int i = 2; i < 16; i++)
            flow_pool[4'(i)] = 16'($urandom);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: labelled flows only, no cooldown
        send_event(FUNC_ADD, 16'h0000, 64'd10, 1'b0, 1'b1, 1'b1, 64'd1, 64'd0);
        send_event(FUNC_ADD, 16'h0000, 64'd20, 1'b1, 1'b0, 1'b1, 64'd1, 64'd0);
        send_event(FUNC_UPDATE, 16'h0000, 64'd30, 1'b1, 1'b1, 1'b0, 64'd1, 64'd0);
        send_event(FUNC_ADD, 16'h0000, 64'd40, 1'b1, 1'b1, 1'b1, 64'd1, 64'd1);
        send_event(FUNC_UPDATE, 16'hFFFF, '1, 1'b1, 1'b1, 1'b1, '1, '1);
        send_event(FUNC_DELETE, 16'h0000, 64'd50, 1'b0, 1'b1, 1'b1, 64'd3, 64'd3);
        send_event(FUNC_RESERVED, 16'hFFFF, 64'd60, 1'b1, 1'b1, 1'b1, 64'd0, 64'd0);

        // age curve: 100 / 1000 / 10000 ns, intervals 50 / 500 / 5000 ns
        choose_setting(CURVE_TYPICAL);
        send_event(FUNC_ADD, 16'h1234, 64'd1000, 1'b1, 1'b0, 1'b1, 64'd1, 64'd0);
        send_event(FUNC_UPDATE, 16'h1234, 64'd1150, 1'b1, 1'b0, 1'b1, 64'd1, 64'd0);
        send_event(FUNC_UPDATE, 16'h1234, 64'd1160, 1'b1, 1'b1, 1'b1, 64'd1, 64'd1);
        send_event(FUNC_UPDATE, 16'h1234, 64'd1170, 1'b1, 1'b1, 1'b1, 64'd0, 64'd1);
        send_event(FUNC_UPDATE, 16'h1234, 64'd1300, 1'b1, 1'b1, 1'b1, 64'd2, 64'd1);
        send_event(FUNC_ADD, 16'h00FF, 64'd5000, 1'b1, 1'b1, 1'b1, 64'd1, 64'd1);
        send_event(FUNC_UPDATE, 16'h00FF, 64'd20000, 1'b1, 1'b1, 1'b1, 64'd4, 64'd1);
        // clock running backwards
        send_event(FUNC_UPDATE, 16'h00FF, 64'd500, 1'b1, 1'b1, 1'b1, 64'd1, 64'd0);
        // expiry saturates at the top of the time range
        send_event(FUNC_ADD, 16'h8000, 64'hFFFF_FFFF_FFFF_FF00, 1'b1, 1'b1, 1'b1, 64'd0, 64'd2);
        send_event(FUNC_UPDATE, 16'h8000, '1, 1'b1, 1'b1, 1'b1, 64'd1, 64'd1);
        send_event(FUNC_ADD, 16'h0001, 64'd0, 1'b1, 1'b1, 1'b1, 64'd3, 64'd2);
        send_event(FUNC_DELETE, 16'h00FF, 64'd20050, 1'b1, 1'b1, 1'b1, 64'd9, 64'd9);
        send_event(FUNC_UPDATE, 16'h00FF, 64'd20100, 1'b1, 1'b1, 1'b1, 64'd1, 64'd0);
        // a dropped delete still clears the slot
        send_event(FUNC_DELETE, 16'h1234, 64'd1350, 1'b1, 1'b1, 1'b0, 64'd1, 64'd1);
        send_event(FUNC_UPDATE, 16'h1234, 64'd1400, 1'b1, 1'b0, 1'b1, 64'd1, 64'd1);

        for (int phase = 0; phase < 8; phase++)
        begin
            choose_setting(phase_curve[3'(phase)]);
            tx_idle_pct = tx_mode[2'(phase)];
            rx_stall_pct <= rx_mode[2'(phase)];
            if (phase == 4)
                squeeze_req <= 1'b1;
            repeat (100) random_event();
        end

        drain();
        $display("Run covered %0d requests over five curve settings and four idling mixes.",
                 request_count);
        $display("Results: %0d seen, %0d emitted, %0d cooling drops, %0d too-young drops.",
                 result_count, emit_count, cooling_count, young_count);
        if (fail_count == 0)
            $display("** flow_event_age_curve_rate_limiter: PASSED **");
        else
            $display("** flow_event_age_curve_rate_limiter: FAILED **");
        $finish;
    end

endmodule
